FILE: hw/rtl/ate_pkg.sv
// ate_pkg: command codes, status codes and fixed field widths of the array table engine.
// No dependencies; ate_if, ate_div and array_table_engine refer to it by scoped names.
package ate_pkg;

    localparam int OP_W   = 4;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int RNG_W  = 4;
    localparam int RES_W  = 40;
    localparam int FIDX_W = 4;
    localparam int STAT_W = 3;
    localparam int LEN_W  = 5;
    localparam int CAPL_W = 5;
    localparam int SUM_W  = 64;
    localparam int FRAC_W = 8;

    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam opcode_t OP_APPEND = 4'd0;
    localparam opcode_t OP_INSERT = 4'd1;
    localparam opcode_t OP_DELETE = 4'd2;
    localparam opcode_t OP_GET    = 4'd3;
    localparam opcode_t OP_SET    = 4'd4;
    localparam opcode_t OP_LSRCH  = 4'd5;
    localparam opcode_t OP_BSRCH  = 4'd6;
    localparam opcode_t OP_MAX    = 4'd7;
    localparam opcode_t OP_MIN    = 4'd8;
    localparam opcode_t OP_SUM    = 4'd9;
    localparam opcode_t OP_AVG    = 4'd10;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_BADIDX   = 3'd1;
    localparam status_t ST_FULL     = 3'd2;
    localparam status_t ST_EMPTY    = 3'd3;
    localparam status_t ST_NOTFOUND = 3'd4;

    localparam logic [CAPL_W-1:0] CAPL_RESET = 5'd16;

endpackage

FILE: hw/rtl/ate_if.sv
// ate_if: command and response channel interfaces (valid/ready plus payload).
// Depends on ate_pkg for field widths.
interface ate_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [ate_pkg::OP_W-1:0]          opcode;
    logic [ate_pkg::POS_W-1:0]         position;
    logic signed [ate_pkg::VAL_W-1:0]  operand_value;
    logic [ate_pkg::RNG_W-1:0]         range_low;
    logic [ate_pkg::RNG_W-1:0]         range_high;

    modport source (output valid, opcode, position, operand_value, range_low, range_high,
                    input ready);
    modport sink   (input valid, opcode, position, operand_value, range_low, range_high,
                    output ready);
endinterface

interface ate_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [ate_pkg::RES_W-1:0]  result_value;
    logic [ate_pkg::FIDX_W-1:0]        found_index;
    logic [ate_pkg::STAT_W-1:0]        status;
    logic [ate_pkg::LEN_W-1:0]         length_now;

    modport source (output valid, result_value, found_index, status, length_now,
                    input ready);
    modport sink   (input valid, result_value, found_index, status, length_now,
                    output ready);
endinterface

FILE: hw/rtl/ate_mem.sv
// ate_mem: element store, one write port and one registered read port.
// No package dependency.
module ate_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: hw/rtl/ate_div.sv
// ate_div: restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ate_pkg for the dividend width.
module ate_div #(
    parameter int DIV_W = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ate_pkg::SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [ate_pkg::SUM_W-1:0] quotient
);
    localparam int CW = $clog2(ate_pkg::SUM_W + 1);

    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [ate_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DIV_W:0]            trial;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[ate_pkg::SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(ate_pkg::SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
            quo_next = {quo_reg[ate_pkg::SUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: hw/rtl/array_table_engine.sv
// array_table_engine: packed array of signed words with list, search and statistics commands.
// Depends on ate_pkg, ate_if, ate_mem and ate_div.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+----------------------------------------------------
//  cmd       | in  | valid/ready      | opcode, position, operand_value, range_low/high
//  rsp       | out | valid/ready      | result_value, found_index, status, length_now
//  cfg       | in  | cfg_we only      | cfg_wdata = capacity_limit
//
// Operation: one item at a time through a small sequencer around a store with one write port
//   and one registered read port. Every element touched by a shift, linear search or scan is
//   read, then used; a binary search reads, then compares, per probe; average then runs the
//   bit-serial divider.
// Reset clears length, state and the output valid; the store itself is not cleared, since
//   only entries below the length are ever read.
// Stalls: cmd.ready is high only while idle. A finished item sits in the output register
//   while the next item is taken; that item's completion waits in S_DONE if rsp is still stalled.
module array_table_engine #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ate_cmd_if.sink                    cmd,
    ate_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [ate_pkg::CAPL_W-1:0] cfg_wdata
);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > ate_pkg::POS_W) ? CNT_W : ate_pkg::POS_W) + 1;
    localparam int BW    = CMP_W + 1;
    localparam int SW    = ate_pkg::SUM_W;

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_SHUP_RD = 5'd2;
    localparam logic [4:0] S_SHUP_WR = 5'd3;
    localparam logic [4:0] S_DEL_CAP = 5'd4;
    localparam logic [4:0] S_SHDN_RD = 5'd5;
    localparam logic [4:0] S_SHDN_WR = 5'd6;
    localparam logic [4:0] S_GET_CAP = 5'd7;
    localparam logic [4:0] S_LIN_RD  = 5'd8;
    localparam logic [4:0] S_LIN_CMP = 5'd9;
    localparam logic [4:0] S_LIN_SW1 = 5'd10;
    localparam logic [4:0] S_LIN_SW2 = 5'd11;
    localparam logic [4:0] S_BIN_CHK = 5'd12;
    localparam logic [4:0] S_BIN_CMP = 5'd13;
    localparam logic [4:0] S_SCAN_RD = 5'd14;
    localparam logic [4:0] S_SCAN_AC = 5'd15;
    localparam logic [4:0] S_DIV_GO  = 5'd16;
    localparam logic [4:0] S_DIV_WT  = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    logic [4:0]                    state_reg, state_next;
    logic [ate_pkg::CAPL_W-1:0]    capl_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [SW-1:0]                 acc_reg, acc_next;
    logic [ate_pkg::FIDX_W-1:0]    fidx_reg, fidx_next;
    logic [ate_pkg::STAT_W-1:0]    stat_reg, stat_next;
    logic signed [BW-1:0]          lo_reg, lo_next, hi_reg, hi_next;

    // latched command
    logic [ate_pkg::OP_W-1:0]      op_reg;
    logic [ate_pkg::POS_W-1:0]     pos_reg;
    logic [DATA_WIDTH-1:0]         val_reg;
    logic [ate_pkg::RNG_W-1:0]     rlo_reg, rhi_reg;

    // output register
    logic                          ov_reg;
    logic [ate_pkg::RES_W-1:0]     ores_reg;
    logic [ate_pkg::FIDX_W-1:0]    ofidx_reg;
    logic [ate_pkg::STAT_W-1:0]    ostat_reg;
    logic [ate_pkg::LEN_W-1:0]     olen_reg;

    // store ports
    logic                          mem_we, mem_re;
    logic [IDX_W-1:0]              mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0]         mem_wdata, mem_rdata;

    logic                          div_start, div_done;
    logic [SW-1:0]                 div_quo;

    logic                          take, load_out;
    logic [CMP_W-1:0]              pos_e, n_e, cap_e, capl_e, idx_e;
    logic [SW-1:0]                 elem64, sum_mag, avg_q;
    logic signed [BW-1:0]          mid_s, nm1_s, rhi_s;
    logic [BW-1:0]                 lohi_sum;
    logic [IDX_W-1:0]              mid_idx;

    assign take      = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_DONE) && (!ov_reg || rsp.ready);

    assign pos_e  = CMP_W'(pos_reg);
    assign n_e    = CMP_W'(count_reg);
    assign idx_e  = CMP_W'(idx_reg);
    assign capl_e = CMP_W'(capl_reg);
    // limits above CAPACITY act as CAPACITY
    assign cap_e  = (capl_e > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : capl_e;

    assign elem64   = SW'($signed(mem_rdata));
    assign lohi_sum = BW'(lo_reg + hi_reg);
    assign mid_s    = $signed(lohi_sum >> 1);
    assign mid_idx  = IDX_W'(mid_s);
    assign nm1_s    = $signed(BW'(count_reg)) - BW'(1);
    assign rhi_s    = $signed(BW'(rhi_reg));

    // average: magnitude of the sum, scaled by 256, divided by the length
    assign sum_mag = acc_reg[SW-1] ? (SW'(0) - acc_reg) : acc_reg;
    assign avg_q   = acc_reg[SW-1] ? (SW'(0) - div_quo) : div_quo;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        fidx_next  = fidx_reg;
        stat_next  = stat_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[IDX_W-1:0];
        mem_wdata  = val_reg;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[IDX_W-1:0];
        div_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                acc_next   = '0;
                fidx_next  = '0;
                stat_next  = ate_pkg::ST_OK;
                idx_next   = '0;
                state_next = S_DONE;
                unique case (op_reg)
                    ate_pkg::OP_APPEND:
                    begin
                        if (n_e < cap_e)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            stat_next = ate_pkg::ST_FULL;
                        end
                    end
                    ate_pkg::OP_INSERT:
                    begin
                        if (pos_e > n_e)
                        begin
                            stat_next = ate_pkg::ST_BADIDX;
                        end
                        else if (n_e >= cap_e)
                        begin
                            stat_next = ate_pkg::ST_FULL;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_SHUP_RD;
                        end
                    end
                    ate_pkg::OP_DELETE, ate_pkg::OP_GET, ate_pkg::OP_SET:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ate_pkg::ST_EMPTY;
                        end
                        else if (pos_e >= n_e)
                        begin
                            stat_next = ate_pkg::ST_BADIDX;
                        end
                        else if (op_reg == ate_pkg::OP_SET)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = IDX_W'(pos_reg);
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = IDX_W'(pos_reg);
                            state_next = (op_reg == ate_pkg::OP_DELETE) ? S_DEL_CAP
                                                                        : S_GET_CAP;
                        end
                    end
                    ate_pkg::OP_LSRCH:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ate_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_LIN_RD;
                        end
                    end
                    ate_pkg::OP_BSRCH:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ate_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            lo_next    = $signed(BW'(rlo_reg));
                            hi_next    = (rhi_s > nm1_s) ? nm1_s : rhi_s;
                            state_next = S_BIN_CHK;
                        end
                    end
                    ate_pkg::OP_MAX, ate_pkg::OP_MIN, ate_pkg::OP_AVG:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ate_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    ate_pkg::OP_SUM:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            // shift up from the top, then drop the new value in
            S_SHUP_RD:
            begin
                if (idx_e > pos_e)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(idx_reg - 1'b1);
                    state_next = S_SHUP_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = IDX_W'(pos_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHUP_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = S_SHUP_RD;
            end
            S_DEL_CAP:
            begin
                acc_next   = elem64;
                idx_next   = CNT_W'(pos_reg);
                state_next = S_SHDN_RD;
            end
            S_SHDN_RD:
            begin
                if ((idx_e + 1'b1) < n_e)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(idx_reg + 1'b1);
                    state_next = S_SHDN_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHDN_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHDN_RD;
            end
            S_GET_CAP:
            begin
                acc_next   = elem64;
                state_next = S_DONE;
            end
            S_LIN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_LIN_CMP;
            end
            S_LIN_CMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    fidx_next = ate_pkg::FIDX_W'(idx_reg);
                    if (idx_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = IDX_W'(idx_reg - 1'b1);
                        state_next = S_LIN_SW1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if ((idx_e + 1'b1) < n_e)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LIN_RD;
                end
                else
                begin
                    stat_next  = ate_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end
            end
            // transposition: hit moves one place down; the key equals the hit value
            S_LIN_SW1:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                state_next = S_LIN_SW2;
            end
            S_LIN_SW2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(idx_reg - 1'b1);
                state_next = S_DONE;
            end
            S_BIN_CHK:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid_idx;
                    state_next = S_BIN_CMP;
                end
                else
                begin
                    stat_next  = ate_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end
            end
            S_BIN_CMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    fidx_next  = ate_pkg::FIDX_W'(mid_s);
                    state_next = S_DONE;
                end
                else
                begin
                    if ($signed(val_reg) < $signed(mem_rdata))
                    begin
                        hi_next = mid_s - BW'(1);
                    end
                    else
                    begin
                        lo_next = mid_s + BW'(1);
                    end
                    state_next = S_BIN_CHK;
                end
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCAN_AC;
            end
            S_SCAN_AC:
            begin
                if ((op_reg == ate_pkg::OP_SUM) || (op_reg == ate_pkg::OP_AVG))
                begin
                    acc_next = acc_reg + elem64;
                end
                else if ((idx_reg == '0) ||
                         ((op_reg == ate_pkg::OP_MAX) && ($signed(acc_reg) < $signed(elem64)))
                         || ((op_reg == ate_pkg::OP_MIN) && ($signed(elem64) < $signed(acc_reg))))
                begin
                    acc_next = elem64;
                end
                if ((idx_e + 1'b1) < n_e)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (op_reg == ate_pkg::OP_AVG)
                begin
                    state_next = S_DIV_GO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WT;
            end
            S_DIV_WT:
            begin
                if (div_done)
                begin
                    acc_next   = avg_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            capl_reg  <= ate_pkg::CAPL_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                capl_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        fidx_reg <= fidx_next;
        stat_reg <= stat_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        if (take)
        begin
            op_reg  <= cmd.opcode;
            pos_reg <= cmd.position;
            val_reg <= DATA_WIDTH'(SW'(cmd.operand_value));
            rlo_reg <= cmd.range_low;
            rhi_reg <= cmd.range_high;
        end
        if (load_out)
        begin
            ores_reg  <= (stat_reg == ate_pkg::ST_OK) ? acc_reg[ate_pkg::RES_W-1:0] : '0;
            ofidx_reg <= fidx_reg;
            ostat_reg <= stat_reg;
            olen_reg  <= ate_pkg::LEN_W'(count_reg);
        end
    end

    assign rsp.valid        = ov_reg;
    assign rsp.result_value = ores_reg;
    assign rsp.found_index  = ofidx_reg;
    assign rsp.status       = ostat_reg;
    assign rsp.length_now   = olen_reg;

    ate_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ate_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_mag[SW-ate_pkg::FRAC_W-1:0], ate_pkg::FRAC_W'(0)}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );
endmodule
